### rtl/dmfb_pkg.sv
// ----------------------------------------------------------------------------
// dmfb_pkg: shared types and helpers for the dot-matrix frame buffer
// Action codes, decoded command format, queue sizing and byte shift helper.
// ----------------------------------------------------------------------------
package dmfb_pkg;

  // Input action codes
  localparam logic [2:0] ACT_PIXEL  = 3'd0;
  localparam logic [2:0] ACT_IMAGE  = 3'd1;
  localparam logic [2:0] ACT_CLEAR  = 3'd2;
  localparam logic [2:0] ACT_UPDATE = 3'd3;
  localparam logic [2:0] ACT_RAW    = 3'd4;

  // Pixel mode codes
  localparam logic [1:0] PIX_DRAW  = 2'd0;
  localparam logic [1:0] PIX_CLEAR = 2'd1;
  localparam logic [1:0] PIX_FLIP  = 2'd2;
  localparam logic [1:0] PIX_NONE  = 2'd3;

  localparam int unsigned ROW_COUNT = 8;
  localparam logic [7:0]  BYTE_ONES = 8'hFF;

  // Command queue depth, power of two
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_AW    = $clog2(Q_DEPTH);

  // Decoded operation executed by the back end
  typedef enum logic [1:0] {
    OP_MERGE,
    OP_CLEAR,
    OP_UPDATE,
    OP_RAW
  } op_t;

  // Row merge function; encoding matches the image mode field
  typedef enum logic [1:0] {
    MRG_CLR,
    MRG_SET,
    MRG_FLIP,
    MRG_OVR
  } mrg_t;

  typedef enum logic {
    BK_IDLE,
    BK_DRAIN
  } bk_state_t;

  typedef struct packed {
    op_t                  op;
    mrg_t                 mrg;
    logic [7:0][7:0]      rows;    // per frame row merge data
    logic [7:0]           row_en;  // frame rows touched by the merge
    logic [7:0]           keep;    // overwrite keep mask
    logic [7:0]           dirty;   // rows to mark dirty
    logic [11:0]          word;    // raw command word
  } cmd_t;

  // Shift a byte left (amt >= 0) or right (amt < 0); 8 or more in size gives 0
  function automatic logic [7:0] shift8(input logic [7:0] v, input logic signed [8:0] amt);
    logic [8:0] neg;
    neg = 9'(-amt);
    if (amt >= 9'sd8 || amt <= -9'sd8) begin
      return 8'd0;
    end else if (!amt[8]) begin
      return v << amt[2:0];
    end else begin
      return v >> neg[2:0];
    end
  endfunction

endpackage

### rtl/dot_matrix_frame_buffer.sv
// ----------------------------------------------------------------------------
// dot_matrix_frame_buffer: 8x8 dot-matrix frame buffer with row dirty mask
// Path: with an empty queue, a raw word is registered in the queue and then
//   in the output register before it shows on out_*; an update first
//   snapshots the dirty mask, then its words go to the output register.
// Throughput: one transaction per cycle for pixel, image, clear and raw while
//   the queue has room; an update holds the execution unit while it sends rows.
// Reset: frame rows cleared, every row marked dirty, queue and output empty.
// ----------------------------------------------------------------------------
module dot_matrix_frame_buffer (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_action,
  input  logic signed [8:0]  in_pos_x,
  input  logic signed [8:0]  in_pos_y,
  input  logic [1:0]         in_mode,
  input  logic [63:0]        in_image,
  input  logic [7:0]         in_cmd_address,
  input  logic [7:0]         in_cmd_data,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic [11:0]        out_word,
  output logic               out_last
);

  // Decode side: every kept action is reduced to one command. Pixel and image
  // actions both become a per-row merge (data byte, row enables, keep mask
  // and rows to mark dirty), so the execution side has a single merge path.
  // Out-of-range pixels and unused action codes are accepted and dropped.
  logic           q_push;
  logic           q_ready;
  logic           q_valid;
  logic           q_pop;
  dmfb_pkg::cmd_t push_cmd;
  dmfb_pkg::cmd_t head_cmd;

  dmfb_front u_front (
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_mode        (in_mode),
    .in_image       (in_image),
    .in_cmd_address (in_cmd_address),
    .in_cmd_data    (in_cmd_data),
    .q_ready        (q_ready),
    .q_push         (q_push),
    .q_cmd          (push_cmd)
  );

  // Queue lets decode keep taking transactions while an update drains.
  dmfb_cmdq u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .q_ready  (q_ready),
    .pop      (q_pop),
    .q_valid  (q_valid),
    .q_cmd    (head_cmd)
  );

  // Execution side owns the frame; commands apply strictly in order, and an
  // update snapshots the dirty mask then sends rows lowest first.
  dmfb_exec u_exec (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (head_cmd),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .out_last  (out_last)
  );

endmodule

### rtl/dmfb_front.sv
// ----------------------------------------------------------------------------
// dmfb_front: input decode
// Classifies each transaction and turns pixel and image actions into one
// per-row merge command for the back end. Dropped actions are absorbed here.
// ----------------------------------------------------------------------------
module dmfb_front (
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_action,
  input  logic signed [8:0]  in_pos_x,
  input  logic signed [8:0]  in_pos_y,
  input  logic [1:0]         in_mode,
  input  logic [63:0]        in_image,
  input  logic [7:0]         in_cmd_address,
  input  logic [7:0]         in_cmd_data,
  input  logic               q_ready,
  output logic               q_push,
  output dmfb_pkg::cmd_t     q_cmd
);

  logic [7:0][7:0] turned;
  logic [7:0]      pix_row;
  logic [7:0]      pix_bit;
  logic            pix_ok;
  logic            useful;
  logic signed [9:0] diff;

  // Turned image row t, bit s = source byte s, bit 7-t
  always_comb begin
    for (int t = 0; t < 8; t++) begin
      for (int s = 0; s < 8; s++) begin
        turned[t][s] = in_image[8*s + 7 - t];
      end
    end
  end

  assign pix_ok  = (in_pos_x[8:3] == 6'd0) && (in_pos_y[8:3] == 6'd0);
  assign pix_row = 8'd1 << in_pos_x[2:0];
  assign pix_bit = (in_mode == dmfb_pkg::PIX_NONE) ? 8'd0 : (8'd1 << in_pos_y[2:0]);

  always_comb begin
    q_cmd      = '0;
    q_cmd.op   = dmfb_pkg::OP_MERGE;
    q_cmd.mrg  = dmfb_pkg::MRG_SET;
    q_cmd.word = {in_cmd_address[3:0], in_cmd_data};
    useful     = 1'b0;
    diff       = '0;
    case (in_action)
      dmfb_pkg::ACT_PIXEL: begin
        useful       = pix_ok;
        q_cmd.row_en = pix_row;
        q_cmd.dirty  = pix_row;
        for (int r = 0; r < 8; r++) begin
          q_cmd.rows[r] = pix_row[r] ? pix_bit : 8'd0;
        end
        case (in_mode)
          dmfb_pkg::PIX_CLEAR: q_cmd.mrg = dmfb_pkg::MRG_CLR;
          dmfb_pkg::PIX_FLIP:  q_cmd.mrg = dmfb_pkg::MRG_FLIP;
          default:             q_cmd.mrg = dmfb_pkg::MRG_SET;
        endcase
      end
      dmfb_pkg::ACT_IMAGE: begin
        useful      = 1'b1;
        q_cmd.mrg   = dmfb_pkg::mrg_t'(in_mode);
        q_cmd.keep  = ~dmfb_pkg::shift8(dmfb_pkg::BYTE_ONES, in_pos_y);
        q_cmd.dirty = dmfb_pkg::shift8(dmfb_pkg::BYTE_ONES, in_pos_x);
        // frame row r takes turned row r - pos_x when that lies in 0..7
        for (int r = 0; r < 8; r++) begin
          diff            = 10'(r) - {in_pos_x[8], in_pos_x};
          q_cmd.row_en[r] = (diff[9:3] == 7'd0);
          q_cmd.rows[r]   = dmfb_pkg::shift8(turned[diff[2:0]], in_pos_y);
        end
      end
      dmfb_pkg::ACT_CLEAR: begin
        useful   = 1'b1;
        q_cmd.op = dmfb_pkg::OP_CLEAR;
      end
      dmfb_pkg::ACT_UPDATE: begin
        useful   = 1'b1;
        q_cmd.op = dmfb_pkg::OP_UPDATE;
      end
      dmfb_pkg::ACT_RAW: begin
        useful   = 1'b1;
        q_cmd.op = dmfb_pkg::OP_RAW;
      end
      default: begin
        useful = 1'b0;
      end
    endcase
  end

  assign in_ready = q_ready;
  assign q_push   = in_valid && q_ready && useful;

endmodule

### rtl/dmfb_cmdq.sv
// ----------------------------------------------------------------------------
// dmfb_cmdq: command queue
// Small FIFO of decoded commands between decode and execution.
// ----------------------------------------------------------------------------
module dmfb_cmdq (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  dmfb_pkg::cmd_t   push_cmd,
  output logic             q_ready,
  input  logic             pop,
  output logic             q_valid,
  output dmfb_pkg::cmd_t   q_cmd
);

  dmfb_pkg::cmd_t              mem_r [dmfb_pkg::Q_DEPTH];
  logic [dmfb_pkg::Q_AW-1:0]   wr_r, wr_nxt;
  logic [dmfb_pkg::Q_AW-1:0]   rd_r, rd_nxt;
  logic [dmfb_pkg::Q_AW:0]     count_r, count_nxt;

  assign q_ready = (count_r != (dmfb_pkg::Q_AW+1)'(dmfb_pkg::Q_DEPTH));
  assign q_valid = (count_r != '0);
  assign q_cmd   = mem_r[rd_r];

  always_comb begin
    wr_nxt    = push ? wr_r + 1'b1 : wr_r;
    rd_nxt    = pop  ? rd_r + 1'b1 : rd_r;
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      wr_r    <= wr_nxt;
      rd_r    <= rd_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_cmd;
    end
  end

endmodule

### rtl/dmfb_exec.sv
// ----------------------------------------------------------------------------
// dmfb_exec: command execution
// Holds the frame and dirty mask, applies merges and clears, and puts raw
// and update words into the output register, one per cycle unless stalled.
// ----------------------------------------------------------------------------
module dmfb_exec (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  dmfb_pkg::cmd_t   q_cmd,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [11:0]      out_word,
  output logic             out_last
);

  dmfb_pkg::bk_state_t state_r, state_nxt;
  logic [7:0][7:0] frame_r, frame_nxt;
  logic [7:0]      dirty_r, dirty_nxt;
  logic [7:0]      pend_r, pend_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [11:0]     out_word_r, out_word_nxt;
  logic            out_last_r, out_last_nxt;
  logic            slot_free;
  logic [2:0]      idx;
  logic [7:0]      pend_rest;
  logic            upd_pop;

  assign slot_free = !out_valid_r || out_ready;

  // raw words need the output slot; other commands only need the idle state
  assign pop = q_valid && (state_r == dmfb_pkg::BK_IDLE) &&
               ((q_cmd.op != dmfb_pkg::OP_RAW) || slot_free);
  assign upd_pop = pop && (q_cmd.op == dmfb_pkg::OP_UPDATE);

  // lowest pending row
  always_comb begin
    idx = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (pend_r[i]) begin
        idx = 3'(i);
      end
    end
  end
  assign pend_rest = pend_r & (pend_r - 8'd1);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dmfb_pkg::BK_IDLE: begin
        if (upd_pop && (dirty_r != 8'd0)) begin
          state_nxt = dmfb_pkg::BK_DRAIN;
        end
      end
      dmfb_pkg::BK_DRAIN: begin
        if (slot_free && (pend_rest == 8'd0)) begin
          state_nxt = dmfb_pkg::BK_IDLE;
        end
      end
      default: state_nxt = dmfb_pkg::BK_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    frame_nxt     = frame_r;
    dirty_nxt     = dirty_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_word_nxt  = out_word_r;
    out_last_nxt  = out_last_r;
    case (state_r)
      dmfb_pkg::BK_IDLE: begin
        if (pop) begin
          case (q_cmd.op)
            dmfb_pkg::OP_MERGE: begin
              dirty_nxt = dirty_r | q_cmd.dirty;
              for (int r = 0; r < 8; r++) begin
                if (q_cmd.row_en[r]) begin
                  case (q_cmd.mrg)
                    dmfb_pkg::MRG_CLR:  frame_nxt[r] = frame_r[r] & ~q_cmd.rows[r];
                    dmfb_pkg::MRG_SET:  frame_nxt[r] = frame_r[r] | q_cmd.rows[r];
                    dmfb_pkg::MRG_FLIP: frame_nxt[r] = frame_r[r] ^ q_cmd.rows[r];
                    default: frame_nxt[r] = (frame_r[r] & q_cmd.keep) | q_cmd.rows[r];
                  endcase
                end
              end
            end
            dmfb_pkg::OP_CLEAR: begin
              frame_nxt = '0;
              dirty_nxt = dmfb_pkg::BYTE_ONES;
            end
            dmfb_pkg::OP_UPDATE: begin
              pend_nxt  = dirty_r;
              dirty_nxt = 8'd0;
            end
            default: begin
              out_valid_nxt = 1'b1;
              out_word_nxt  = q_cmd.word;
              out_last_nxt  = 1'b1;
            end
          endcase
        end
      end
      dmfb_pkg::BK_DRAIN: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = {4'(idx) + 4'd1, frame_r[idx]};
          out_last_nxt  = (pend_rest == 8'd0);
          pend_nxt      = pend_rest;
        end
      end
      default: begin
        pend_nxt = 8'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dmfb_pkg::BK_IDLE;
      frame_r     <= '0;
      dirty_r     <= dmfb_pkg::BYTE_ONES;
      pend_r      <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      frame_r     <= frame_nxt;
      dirty_r     <= dirty_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign out_last  = out_last_r;

  // drain state always has a row left to send
  a_drain_pending: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == dmfb_pkg::BK_DRAIN |-> pend_r != 8'd0)
    else $error("drain with empty pending mask");

  // an update leaves the dirty mask clean
  a_update_clears: assert property (@(posedge clk) disable iff (!rst_n)
    upd_pop |=> dirty_r == 8'd0)
    else $error("dirty mask not cleared by update");

  // a shown word holds until the receiver takes it
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=>
      out_valid_r && $stable(out_word_r) && $stable(out_last_r))
    else $error("output word changed while stalled");

endmodule

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for dot_matrix_frame_buffer
// Pixel, image, clear, update and raw transactions go in through a bursty
// driver. A shadow copy of the frame and its dirty mask predicts every
// command word, and each word out of the block is checked in order.
// ----------------------------------------------------------------------------
module tb;

  // Action codes the block must ignore
  localparam logic [2:0] ACT_UNUSED_LO = 3'd5;
  localparam logic [2:0] ACT_UNUSED_HI = 3'd7;

  localparam int RANDOM_OPS   = 400;
  localparam int CYCLE_LIMIT  = 250000;
  localparam int HOLD_AFTER   = 80;    // accepted transactions before the long stall
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 24;
  localparam int REPORT_MAX   = 10;

  typedef struct {
    logic [2:0]        action;
    logic signed [8:0] pos_x;
    logic signed [8:0] pos_y;
    logic [1:0]        mode;
    logic [63:0]       image;
    logic [7:0]        cmd_address;
    logic [7:0]        cmd_data;
  } frame_op_t;

  typedef struct {
    logic [11:0] word;
    logic        last;
  } dev_word_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [2:0]         in_action;
  logic signed [8:0]  in_pos_x;
  logic signed [8:0]  in_pos_y;
  logic [1:0]         in_mode;
  logic [63:0]        in_image;
  logic [7:0]         in_cmd_address;
  logic [7:0]         in_cmd_data;
  logic               out_valid;
  logic               out_ready;
  logic [11:0]        out_word;
  logic               out_last;

  dot_matrix_frame_buffer i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_mode        (in_mode),
    .in_image       (in_image),
    .in_cmd_address (in_cmd_address),
    .in_cmd_data    (in_cmd_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_word       (out_word),
    .out_last       (out_last)
  );

  // Stimulus and expectation stores
  frame_op_t pending_ops[$];
  dev_word_t expected_words[$];
  int        ops_total;
  int        ops_accepted;
  int        err_count;
  int        cycle_count;

  // Shadow frame state
  logic [7:0] shadow_rows [dmfb_pkg::ROW_COUNT];
  logic [7:0] shadow_dirty;

  // Driver and receiver state
  logic      in_fire_q;      // the transaction on the bus was taken at the last edge
  logic      drv_valid_nx;
  frame_op_t drv_op;
  int        burst_left;
  int        gap_left;
  int        hold_left;
  logic      hold_done;
  int        rx_style;
  int        rx_style_left;

  // --------------------------------------------------------------------------
  // Shadow model
  // --------------------------------------------------------------------------

  // Byte shift: left for amt >= 0, right otherwise; |amt| >= 8 clears it
  function automatic logic [7:0] shift_byte(input logic [7:0] v, input int amt);
    if (amt >= 8 || amt <= -8) return 8'h00;
    if (amt >= 0) return 8'(v << amt);
    return v >> (-amt);
  endfunction

  // Row t of the image turned by 90 degrees: bit s = source byte s, bit 7-t
  function automatic logic [7:0] turned_image_row(input logic [63:0] img, input int t);
    logic [7:0] r;
    r = '0;
    for (int s = 0; s < 8; s++) r[s] = img[8*s + 7 - t];
    return r;
  endfunction

  function automatic void reset_shadow();
    foreach (shadow_rows[r]) shadow_rows[r] = '0;
    shadow_dirty = dmfb_pkg::BYTE_ONES;
  endfunction

  // Apply one accepted transaction to the shadow frame; queue any words it emits
  function automatic void apply_frame_op(input frame_op_t op);
    int         px;
    int         py;
    int         row;
    int         last_row;
    logic [7:0] w;
    logic [7:0] keep;
    dev_word_t  dw;
    px = op.pos_x;
    py = op.pos_y;
    case (op.action)
      dmfb_pkg::ACT_PIXEL: begin
        // out-of-range coordinates are dropped without marking anything
        if (px >= 0 && px <= 7 && py >= 0 && py <= 7) begin
          shadow_dirty[px] = 1'b1;
          case (op.mode)
            dmfb_pkg::PIX_DRAW:  shadow_rows[px][py] = 1'b1;
            dmfb_pkg::PIX_CLEAR: shadow_rows[px][py] = 1'b0;
            dmfb_pkg::PIX_FLIP:  shadow_rows[px][py] = ~shadow_rows[px][py];
            default:   ;   // mode none: only the dirty mark
          endcase
        end
      end
      dmfb_pkg::ACT_IMAGE: begin
        keep = ~shift_byte(dmfb_pkg::BYTE_ONES, py);
        for (int t = 0; t < 8; t++) begin
          row = px + t;
          if (row >= 0 && row <= 7) begin
            w = shift_byte(turned_image_row(op.image, t), py);
            case (dmfb_pkg::mrg_t'(op.mode))
              dmfb_pkg::MRG_CLR:  shadow_rows[row] = shadow_rows[row] & ~w;
              dmfb_pkg::MRG_SET:  shadow_rows[row] = shadow_rows[row] | w;
              dmfb_pkg::MRG_FLIP: shadow_rows[row] = shadow_rows[row] ^ w;
              default:  shadow_rows[row] = (shadow_rows[row] & keep) | w;
            endcase
          end
        end
        shadow_dirty = shadow_dirty | shift_byte(dmfb_pkg::BYTE_ONES, px);
      end
      dmfb_pkg::ACT_CLEAR: reset_shadow();
      dmfb_pkg::ACT_UPDATE: begin
        last_row = 0;
        for (int r = 0; r < 8; r++) if (shadow_dirty[r]) last_row = r;
        for (int r = 0; r < 8; r++) begin
          if (shadow_dirty[r]) begin
            dw.word = {4'(r + 1), shadow_rows[r]};
            dw.last = (r == last_row);
            expected_words.push_back(dw);
          end
        end
        shadow_dirty = '0;
      end
      dmfb_pkg::ACT_RAW: begin
        dw.word = {op.cmd_address[3:0], op.cmd_data};
        dw.last = 1'b1;
        expected_words.push_back(dw);
      end
      default: ;   // unused action codes
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus construction
  // --------------------------------------------------------------------------

  function automatic void add_op(input logic [2:0] action, input int px, input int py,
                                 input logic [1:0] mode, input logic [63:0] image,
                                 input logic [7:0] addr, input logic [7:0] data);
    frame_op_t op;
    op.action      = action;
    op.pos_x       = 9'(px);
    op.pos_y       = 9'(py);
    op.mode        = mode;
    op.image       = image;
    op.cmd_address = addr;
    op.cmd_data    = data;
    pending_ops.push_back(op);
  endfunction

  function automatic logic [63:0] rand_image();
    return {$urandom, $urandom};
  endfunction

  function automatic void build_directed();
    // all rows dirty after reset
    add_op(dmfb_pkg::ACT_UPDATE, 0, 0, dmfb_pkg::PIX_DRAW, '0, 8'h00, 8'h00);
    // clean mask: nothing out
    add_op(dmfb_pkg::ACT_UPDATE, 0, 0, dmfb_pkg::PIX_DRAW, '0, 8'h00, 8'h00);
    add_op(dmfb_pkg::ACT_PIXEL, 0, 0, dmfb_pkg::PIX_DRAW, '0, 8'h00, 8'h00);
    add_op(dmfb_pkg::ACT_PIXEL, 7, 7, dmfb_pkg::PIX_DRAW, '0, 8'h00, 8'h00);
    add_op(dmfb_pkg::ACT_PIXEL, 3, 5, dmfb_pkg::PIX_FLIP, '0, 8'h00, 8'h00);
    add_op(dmfb_pkg::ACT_PIXEL, 0, 0, dmfb_pkg::PIX_CLEAR, '0, 8'h00, 8'h00);
    // marks row, no change
    add_op(dmfb_pkg::ACT_PIXEL, 5, 2, dmfb_pkg::PIX_NONE, '0, 8'h00, 8'h00);
    // out of range
    add_op(dmfb_pkg::ACT_PIXEL, 8, 0, dmfb_pkg::PIX_DRAW, '0, 8'h00, 8'h00);
    add_op(dmfb_pkg::ACT_PIXEL, 0, -1, dmfb_pkg::PIX_DRAW, '0, 8'h00, 8'h00);
    add_op(dmfb_pkg::ACT_PIXEL, -128, 255, dmfb_pkg::PIX_FLIP, '0, 8'h00, 8'h00);
    add_op(dmfb_pkg::ACT_UPDATE, 0, 0, dmfb_pkg::PIX_DRAW, '0, 8'h00, 8'h00);
    add_op(dmfb_pkg::ACT_IMAGE, 0, 0, dmfb_pkg::MRG_SET, 64'h0123_4567_89AB_CDEF,
           8'h00, 8'h00);
    add_op(dmfb_pkg::ACT_IMAGE, -3, 2, dmfb_pkg::MRG_OVR, rand_image(), 8'h00, 8'h00);
    add_op(dmfb_pkg::ACT_IMAGE, 2, -3, dmfb_pkg::MRG_FLIP, '1, 8'h00, 8'h00);
    add_op(dmfb_pkg::ACT_IMAGE, 5, -7, dmfb_pkg::MRG_CLR, rand_image(), 8'h00, 8'h00);
    // large row offset
    add_op(dmfb_pkg::ACT_IMAGE, 8, 0, dmfb_pkg::MRG_SET, '1, 8'h00, 8'h00);
    // large offset and shift
    add_op(dmfb_pkg::ACT_IMAGE, -8, 8, dmfb_pkg::MRG_OVR, '1, 8'h00, 8'h00);
    add_op(dmfb_pkg::ACT_IMAGE, 255, -128, dmfb_pkg::MRG_OVR, rand_image(),
           8'h00, 8'h00);
    add_op(dmfb_pkg::ACT_UPDATE, 0, 0, dmfb_pkg::PIX_DRAW, '0, 8'h00, 8'h00);
    add_op(dmfb_pkg::ACT_RAW, 0, 0, dmfb_pkg::PIX_DRAW, '0, 8'hFF, 8'hFF);
    add_op(dmfb_pkg::ACT_RAW, 0, 0, dmfb_pkg::PIX_DRAW, '0, 8'h00, 8'h00);
    add_op(ACT_UNUSED_LO, 3, 3, dmfb_pkg::PIX_DRAW, '1, 8'h12, 8'h34);
    add_op(ACT_UNUSED_HI, 4, 4, dmfb_pkg::MRG_OVR, '1, 8'h56, 8'h78);
    add_op(dmfb_pkg::ACT_CLEAR, 0, 0, dmfb_pkg::PIX_DRAW, '0, 8'h00, 8'h00);
    add_op(dmfb_pkg::ACT_UPDATE, 0, 0, dmfb_pkg::PIX_DRAW, '0, 8'h00, 8'h00);
  endfunction

  // Mostly well-formed traffic with random content; ignored items are extra
  function automatic void build_random();
    int        n_effective;
    int        k;
    frame_op_t op;
    n_effective = 0;
    while (n_effective < RANDOM_OPS) begin
      k              = $urandom_range(0, 99);
      op.pos_x       = 9'($urandom);
      op.pos_y       = 9'($urandom);
      op.mode        = 2'($urandom);
      op.image       = rand_image();
      op.cmd_address = 8'($urandom);
      op.cmd_data    = 8'($urandom);
      if (k < 35) begin
        op.action = dmfb_pkg::ACT_PIXEL;
        if ($urandom_range(0, 9) != 0) begin
          op.pos_x = 9'($urandom_range(0, 7));
          op.pos_y = 9'($urandom_range(0, 7));
        end
      end else if (k < 60) begin
        op.action = dmfb_pkg::ACT_IMAGE;
        if ($urandom_range(0, 7) != 0) begin
          // offsets around the visible window, edges included
          op.pos_x = 9'(int'($urandom_range(0, 18)) - 9);
          op.pos_y = 9'(int'($urandom_range(0, 18)) - 9);
        end
      end else if (k < 63) begin
        op.action = dmfb_pkg::ACT_CLEAR;
      end else if (k < 78) begin
        op.action = dmfb_pkg::ACT_UPDATE;
      end else if (k < 97) begin
        op.action = dmfb_pkg::ACT_RAW;
      end else begin
        op.action = 3'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
      end
      pending_ops.push_back(op);
      if (op.action == dmfb_pkg::ACT_PIXEL) begin
        if (op.pos_x >= 0 && op.pos_x <= 7 && op.pos_y >= 0 && op.pos_y <= 7)
          n_effective++;
      end else if (op.action <= dmfb_pkg::ACT_RAW) begin
        n_effective++;
      end
    end
  endfunction

  function automatic void note_error(input string what, input dev_word_t exp_w,
                                     input logic [11:0] got_word, input logic got_last);
    err_count++;
    if (err_count <= REPORT_MAX)
      $display("mismatch (%s): expected word=%03h last=%0b, got word=%03h last=%0b",
               what, exp_w.word, exp_w.last, got_word, got_last);
  endfunction

  // --------------------------------------------------------------------------
  // Clock, watchdog
  // --------------------------------------------------------------------------

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop well past the slowest legal run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Driver: bursts of transactions separated by random gaps. Valid holds with
  // a stable payload until the transaction is taken.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_fire_q)) begin
      drv_valid_nx = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_ops.size() > 0) begin
        drv_op = pending_ops.pop_front();
        in_action      <= drv_op.action;
        in_pos_x       <= drv_op.pos_x;
        in_pos_y       <= drv_op.pos_y;
        in_mode        <= drv_op.mode;
        in_image       <= drv_op.image;
        in_cmd_address <= drv_op.cmd_address;
        in_cmd_data    <= drv_op.cmd_data;
        drv_valid_nx   = 1'b1;
        if (burst_left <= 1) begin
          // one in four bursts is a long back-to-back stretch
          burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(1, 10);
          gap_left   = $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end
      in_valid <= drv_valid_nx;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: ready follows a changing style (always, mostly, rarely), plus
  // one long hold-off that backs the block up into its input.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst_n) begin
      if (!hold_done && ops_accepted >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (rx_style_left == 0) begin
          rx_style      = $urandom_range(0, 2);
          rx_style_left = $urandom_range(8, 64);
        end else begin
          rx_style_left--;
        end
        case (rx_style)
          0:       out_ready <= 1'b1;
          1:       out_ready <= ($urandom_range(0, 3) != 0);
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: predicts on each accepted input transaction, then checks each
  // output transaction against the oldest predicted word.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    frame_op_t seen_op;
    dev_word_t exp_w;
    if (rst_n) begin
      in_fire_q <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        seen_op.action      = in_action;
        seen_op.pos_x       = in_pos_x;
        seen_op.pos_y       = in_pos_y;
        seen_op.mode        = in_mode;
        seen_op.image       = in_image;
        seen_op.cmd_address = in_cmd_address;
        seen_op.cmd_data    = in_cmd_data;
        apply_frame_op(seen_op);
        ops_accepted++;
      end
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          exp_w.word = 'x;
          exp_w.last = 1'bx;
          note_error("unexpected word", exp_w, out_word, out_last);
        end else begin
          exp_w = expected_words.pop_front();
          if (out_word !== exp_w.word || out_last !== exp_w.last)
            note_error("wrong field", exp_w, out_word, out_last);
        end
      end
    end else begin
      in_fire_q <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    dev_word_t left_w;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_action      = dmfb_pkg::ACT_PIXEL;
    in_pos_x       = '0;
    in_pos_y       = '0;
    in_mode        = dmfb_pkg::PIX_DRAW;
    in_image       = '0;
    in_cmd_address = '0;
    in_cmd_data    = '0;
    out_ready      = 1'b0;
    in_fire_q      = 1'b0;
    ops_accepted   = 0;
    err_count      = 0;
    cycle_count    = 0;
    burst_left     = 0;
    gap_left       = 0;
    hold_left      = 0;
    hold_done      = 1'b0;
    rx_style       = 0;
    rx_style_left  = 0;
    reset_shadow();

    build_directed();
    build_random();
    ops_total = pending_ops.size();

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // all input transactions taken, then every predicted word seen
    while (ops_accepted < ops_total) @(posedge clk);
    while (expected_words.size() > 0) @(posedge clk);
    // watch a little longer for stray words
    repeat (DRAIN_CYCLES) @(posedge clk);

    while (expected_words.size() > 0) begin
      left_w = expected_words.pop_front();
      note_error("missing word", left_w, 'x, 1'bx);
    end

    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### dot_matrix_frame_buffer.f
rtl/dmfb_pkg.sv
rtl/dmfb_front.sv
rtl/dmfb_cmdq.sv
rtl/dmfb_exec.sv
rtl/dot_matrix_frame_buffer.sv
bench/tb.sv
